>>> rtl/sscrg_pkg.sv
// Package: shared types, widths and defaults for the span sprite clip run generator.
`default_nettype none
package sscrg_pkg;

    // Field widths
    localparam int unsigned WordW  = 16;
    localparam int unsigned FrameW = 8;
    localparam int unsigned PosW   = 13;
    localparam int unsigned DimW   = 11;
    localparam int unsigned ColW   = 11;
    localparam int unsigned RowW   = 10;
    localparam int unsigned DstW   = 14;
    localparam int unsigned SrcW   = 10;
    localparam int unsigned LenW   = 11;
    localparam int unsigned CfgIdxW = 4;

    // Parameter defaults
    localparam int unsigned MaxSpriteWidthDef = 1024;
    localparam int unsigned JobDepthDef       = 2;
    localparam int unsigned RunDepthDef       = 2;

    // Largest column and row values held by the walker
    localparam logic [ColW-1:0] ColMax = '1;
    localparam logic [DimW-1:0] RowLast = 11'd1023;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_SPRITE_X      = 4'd0,
        CFG_SPRITE_Y      = 4'd1,
        CFG_SPRITE_WIDTH  = 4'd2,
        CFG_SPRITE_HEIGHT = 4'd3,
        CFG_CLIP_LEFT     = 4'd4,
        CFG_CLIP_TOP      = 4'd5,
        CFG_CLIP_RIGHT    = 4'd6,
        CFG_CLIP_BOTTOM   = 4'd7
    } t_cfg_idx;

    // Configuration register file contents
    typedef struct packed {
        logic [PosW-1:0] sprite_x;
        logic [PosW-1:0] sprite_y;
        logic [DimW-1:0] sprite_width;
        logic [DimW-1:0] sprite_height;
        logic [PosW-1:0] clip_left;
        logic [PosW-1:0] clip_top;
        logic [PosW-1:0] clip_right;
        logic [PosW-1:0] clip_bottom;
    } t_cfg;

    // Drawn span handed from the front walker to the clipper
    typedef struct packed {
        logic [ColW-1:0]   c0;
        logic [ColW-1:0]   c1;
        logic [RowW-1:0]   row;
        logic [FrameW-1:0] frame;
    } t_job;

    // Visible run waiting at the output
    typedef struct packed {
        logic [DstW-1:0]   dst_x;
        logic [DstW-1:0]   dst_y;
        logic [SrcW-1:0]   src_x;
        logic [SrcW-1:0]   src_y;
        logic [LenW-1:0]   run_length;
        logic [FrameW-1:0] src_frame;
    } t_run;

endpackage
`default_nettype wire

>>> rtl/sscrg_fifo.sv
// Module: small register queue with first-word fall-through output.
`default_nettype none
module sscrg_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    output logic                  o_full,
    input  wire logic             i_rd,
    output logic [WIDTH-1:0]      o_rd_data,
    output logic                  o_empty
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0]  r_count, n_count;
    logic             wr_en, rd_en;

    assign o_full    = (r_count == CntFull);
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign wr_en     = i_wr && !o_full;
    assign rd_en     = i_rd && !o_empty;

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule
`default_nettype wire

>>> rtl/sscrg_front.sv
// Module: span stream walker; tracks row, column and draw state, emits drawn spans.
`default_nettype none
module sscrg_front #(
    parameter int unsigned MAX_SPRITE_WIDTH = sscrg_pkg::MaxSpriteWidthDef
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire sscrg_pkg::t_cfg               i_cfg,
    input  wire logic                          i_accept,
    input  wire logic [sscrg_pkg::WordW-1:0]   i_word,
    input  wire logic [sscrg_pkg::FrameW-1:0]  i_frame,
    output logic                               o_job_wr,
    output sscrg_pkg::t_job                    o_job
);

    localparam int unsigned WideW = sscrg_pkg::WordW + 1;
    localparam logic [12:0] MaxW  = 13'(MAX_SPRITE_WIDTH);

    logic [sscrg_pkg::RowW-1:0] r_row,   n_row;
    logic [sscrg_pkg::ColW-1:0] r_col,   n_col;
    logic [sscrg_pkg::ColW-1:0] r_spans, n_spans;
    logic                       r_draw,  n_draw;
    logic                       r_hdr,   n_hdr;

    logic [sscrg_pkg::WordW-2:0] hdr_cnt;
    logic [WideW-1:0]            col_sum;
    logic [12:0]                 width_lim;
    logic [sscrg_pkg::ColW-1:0]  spans_dec;
    logic [sscrg_pkg::DimW-1:0]  height;
    logic [sscrg_pkg::DimW-1:0]  row_inc;
    logic                        row_end;

    assign hdr_cnt   = i_word[sscrg_pkg::WordW-1:1];
    assign col_sum   = {1'b0, i_word} + {{(WideW - sscrg_pkg::ColW){1'b0}}, r_col};
    assign width_lim = ({2'b0, i_cfg.sprite_width} > MaxW) ? MaxW
                                                          : {2'b0, i_cfg.sprite_width};
    assign spans_dec = (r_spans != '0) ? r_spans - 1'b1 : '0;
    assign height    = (i_cfg.sprite_height != '0) ? i_cfg.sprite_height
                                                   : sscrg_pkg::DimW'(1);
    assign row_inc   = {1'b0, r_row} + 1'b1;

    // Drawn span job: start column and end column cut at the sprite width
    always_comb begin
        o_job.c0    = r_col;
        o_job.c1    = (col_sum > {4'b0, width_lim}) ? width_lim[sscrg_pkg::ColW-1:0]
                                                   : col_sum[sscrg_pkg::ColW-1:0];
        o_job.row   = r_row;
        o_job.frame = i_frame;
        o_job_wr    = i_accept && !r_hdr && r_draw && (i_word != '0);
    end

    // Walker next state
    always_comb begin
        n_row   = r_row;
        n_col   = r_col;
        n_spans = r_spans;
        n_draw  = r_draw;
        n_hdr   = r_hdr;
        row_end = 1'b0;
        if (i_accept) begin
            if (r_hdr) begin
                n_draw = i_word[0];
                n_col  = '0;
                if (hdr_cnt == '0) begin
                    row_end = 1'b1;
                end else begin
                    n_spans = (hdr_cnt > {4'b0, sscrg_pkg::ColMax}) ? sscrg_pkg::ColMax
                              : hdr_cnt[sscrg_pkg::ColW-1:0];
                    n_hdr   = 1'b0;
                end
            end else begin
                n_col   = (col_sum > {6'b0, sscrg_pkg::ColMax}) ? sscrg_pkg::ColMax
                          : col_sum[sscrg_pkg::ColW-1:0];
                n_draw  = !r_draw;
                n_spans = spans_dec;
                row_end = (spans_dec == '0);
            end
            // End of row: step to next sprite row, wrap at sprite height or past row 1023
            if (row_end) begin
                n_row   = ((row_inc >= height) || (row_inc > sscrg_pkg::RowLast)) ? '0
                          : row_inc[sscrg_pkg::RowW-1:0];
                n_col   = '0;
                n_spans = '0;
                n_hdr   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_spans <= '0;
            r_draw  <= 1'b0;
            r_hdr   <= 1'b1;
        end else begin
            r_row   <= n_row;
            r_col   <= n_col;
            r_spans <= n_spans;
            r_draw  <= n_draw;
            r_hdr   <= n_hdr;
        end
    end

endmodule
`default_nettype wire

>>> rtl/sscrg_back.sv
// Module: clipper; places a drawn span on screen and trims it to the clip window.
`default_nettype none
module sscrg_back (
    input  wire sscrg_pkg::t_cfg  i_cfg,
    input  wire sscrg_pkg::t_job  i_job,
    input  wire logic             i_job_valid,
    input  wire logic             i_out_full,
    output logic                  o_job_take,
    output logic                  o_run_wr,
    output sscrg_pkg::t_run       o_run
);

    logic signed [14:0] sx, sy, y, lo_raw, hi_raw, lo, hi;
    logic signed [14:0] left, right, top, bottom;
    logic signed [14:0] src_x, len;
    logic               visible;

    // Screen placement in 15-bit signed arithmetic
    assign sx     = $signed({{2{i_cfg.sprite_x[12]}}, i_cfg.sprite_x});
    assign sy     = $signed({{2{i_cfg.sprite_y[12]}}, i_cfg.sprite_y});
    assign y      = sy + $signed({5'b0, i_job.row});
    assign lo_raw = sx + $signed({4'b0, i_job.c0});
    assign hi_raw = sx + $signed({4'b0, i_job.c1});
    assign left   = $signed({2'b0, i_cfg.clip_left});
    assign right  = $signed({2'b0, i_cfg.clip_right});
    assign top    = $signed({2'b0, i_cfg.clip_top});
    assign bottom = $signed({2'b0, i_cfg.clip_bottom});

    // Clip against the window; right and bottom are exclusive
    assign lo      = (lo_raw < left) ? left : lo_raw;
    assign hi      = (hi_raw > right) ? right : hi_raw;
    assign visible = (y >= top) && (y < bottom) && (hi > lo);
    assign src_x   = lo - sx;
    assign len     = hi - lo;

    // One job per cycle while the output queue has room
    assign o_job_take = i_job_valid && !i_out_full;
    assign o_run_wr   = o_job_take && visible;

    always_comb begin
        o_run.dst_x      = lo[sscrg_pkg::DstW-1:0];
        o_run.dst_y      = y[sscrg_pkg::DstW-1:0];
        o_run.src_x      = src_x[sscrg_pkg::SrcW-1:0];
        o_run.src_y      = i_job.row;
        o_run.run_length = len[sscrg_pkg::LenW-1:0];
        o_run.src_frame  = i_job.frame;
    end

endmodule
`default_nettype wire

>>> rtl/span_sprite_clip_run_generator.sv
// Top level: span sprite clip run generator.
//
// Input channel is a queue push side: span_word and frame_number are taken at
// a clock edge with push high and full low. Each sprite row starts with a
// header word (span count in bits 15:1, bit 0 set when the first span is
// drawn) followed by span lengths alternating drawn and transparent.
// Result channel is a queue pop side: while empty is low the oldest run is on
// the o_ ports; it is consumed at an edge with pop high. Each visible piece of
// a drawn span gives one run; clipped spans and headers give nothing.
// Configuration: one transaction on i_cfg_valid/o_cfg_ready writes register
// i_cfg_index; ready is always high. Write only while the block is idle.
// Throughput: one word per cycle while full is low; the span walker updates
// its row and column state as each word is accepted, and the clipper handles
// one drawn span per cycle while the run queue has room. The walker writes a
// drawn span into the span queue as its word is accepted; the clipper moves it
// into the run queue, where the run is on the o_ ports until it is popped.
// When the receiver stops popping, the run queue fills, then the span queue,
// then full rises; nothing is dropped. Synchronous reset clears both queues
// and the walker (header expected) and loads the register defaults.
`default_nettype none
module span_sprite_clip_run_generator #(
    parameter int unsigned MAX_SPRITE_WIDTH = sscrg_pkg::MaxSpriteWidthDef,
    parameter int unsigned JOB_DEPTH        = sscrg_pkg::JobDepthDef,
    parameter int unsigned RUN_DEPTH        = sscrg_pkg::RunDepthDef
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // span word channel
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [sscrg_pkg::WordW-1:0]    i_span_word,
    input  wire logic [sscrg_pkg::FrameW-1:0]   i_frame_number,
    // run channel
    output logic                                empty,
    input  wire logic                           pop,
    output logic signed [sscrg_pkg::DstW-1:0]   o_dst_x,
    output logic signed [sscrg_pkg::DstW-1:0]   o_dst_y,
    output logic [sscrg_pkg::SrcW-1:0]          o_src_x,
    output logic [sscrg_pkg::SrcW-1:0]          o_src_y,
    output logic [sscrg_pkg::LenW-1:0]          o_run_length,
    output logic [sscrg_pkg::FrameW-1:0]        o_src_frame,
    // configuration write channel
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [sscrg_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [sscrg_pkg::PosW-1:0]     i_cfg_data
);

    localparam int unsigned JobW = $bits(sscrg_pkg::t_job);
    localparam int unsigned RunW = $bits(sscrg_pkg::t_run);

    sscrg_pkg::t_cfg r_cfg;
    sscrg_pkg::t_job front_job, queued_job;
    sscrg_pkg::t_run back_run, out_run;
    logic            accept;
    logic            job_wr, job_empty, job_take;
    logic            run_wr, run_full;
    logic [JobW-1:0] job_rd_bits;
    logic [RunW-1:0] run_rd_bits;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sprite_x      <= '0;
            r_cfg.sprite_y      <= '0;
            r_cfg.sprite_width  <= sscrg_pkg::DimW'(1);
            r_cfg.sprite_height <= sscrg_pkg::DimW'(1);
            r_cfg.clip_left     <= '0;
            r_cfg.clip_top      <= '0;
            r_cfg.clip_right    <= sscrg_pkg::PosW'(4096);
            r_cfg.clip_bottom   <= sscrg_pkg::PosW'(4096);
        end else if (i_cfg_valid) begin
            case (sscrg_pkg::t_cfg_idx'(i_cfg_index))
                sscrg_pkg::CFG_SPRITE_X:      r_cfg.sprite_x <= i_cfg_data;
                sscrg_pkg::CFG_SPRITE_Y:      r_cfg.sprite_y <= i_cfg_data;
                sscrg_pkg::CFG_SPRITE_WIDTH: begin
                    r_cfg.sprite_width <= i_cfg_data[sscrg_pkg::DimW-1:0];
                end
                sscrg_pkg::CFG_SPRITE_HEIGHT: begin
                    r_cfg.sprite_height <= i_cfg_data[sscrg_pkg::DimW-1:0];
                end
                sscrg_pkg::CFG_CLIP_LEFT:     r_cfg.clip_left   <= i_cfg_data;
                sscrg_pkg::CFG_CLIP_TOP:      r_cfg.clip_top    <= i_cfg_data;
                sscrg_pkg::CFG_CLIP_RIGHT:    r_cfg.clip_right  <= i_cfg_data;
                sscrg_pkg::CFG_CLIP_BOTTOM:   r_cfg.clip_bottom <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front: span stream walker
    sscrg_front #(
        .MAX_SPRITE_WIDTH(MAX_SPRITE_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_accept(accept),
        .i_word  (i_span_word),
        .i_frame (i_frame_number),
        .o_job_wr(job_wr),
        .o_job   (front_job)
    );

    // Span queue between walker and clipper
    sscrg_fifo #(
        .WIDTH(JobW),
        .DEPTH(JOB_DEPTH)
    ) u_job_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (job_wr),
        .i_wr_data(front_job),
        .o_full   (full),
        .i_rd     (job_take),
        .o_rd_data(job_rd_bits),
        .o_empty  (job_empty)
    );

    assign queued_job = job_rd_bits;

    // Back: clipper
    sscrg_back u_back (
        .i_cfg      (r_cfg),
        .i_job      (queued_job),
        .i_job_valid(!job_empty),
        .i_out_full (run_full),
        .o_job_take (job_take),
        .o_run_wr   (run_wr),
        .o_run      (back_run)
    );

    // Run queue at the output
    sscrg_fifo #(
        .WIDTH(RunW),
        .DEPTH(RUN_DEPTH)
    ) u_run_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (run_wr),
        .i_wr_data(back_run),
        .o_full   (run_full),
        .i_rd     (pop),
        .o_rd_data(run_rd_bits),
        .o_empty  (empty)
    );

    assign out_run      = run_rd_bits;
    assign o_dst_x      = $signed(out_run.dst_x);
    assign o_dst_y      = $signed(out_run.dst_y);
    assign o_src_x      = out_run.src_x;
    assign o_src_y      = out_run.src_y;
    assign o_run_length = out_run.run_length;
    assign o_src_frame  = out_run.src_frame;

endmodule
`default_nettype wire

>>> bench/span_sprite_clip_run_generator_tb.sv
// Testbench for the span sprite clip run generator: row/span streams in, clipped runs checked.
module span_sprite_clip_run_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam realtime CLK_HALF     = 6.0;
    localparam int      CYCLE_LIMIT  = 500000;
    localparam int      DRAIN_CYCLES = 6;
    localparam int      MaxW         = int'(sscrg_pkg::MaxSpriteWidthDef);
    localparam int      PHASE_WORDS  = 24;
    localparam int      TALL_ROWS    = 1030;

    typedef struct packed {
        logic [sscrg_pkg::WordW-1:0]  word;
        logic [sscrg_pkg::FrameW-1:0] frame;
    } t_span_feed;

    // DUT connections
    logic                                i_clk          = 1'b0;
    logic                                i_rst_n        = 1'b0;
    logic                                push           = 1'b0;
    logic                                full;
    logic [sscrg_pkg::WordW-1:0]         i_span_word    = '0;
    logic [sscrg_pkg::FrameW-1:0]        i_frame_number = '0;
    logic                                empty;
    logic                                pop            = 1'b0;
    logic signed [sscrg_pkg::DstW-1:0]   o_dst_x;
    logic signed [sscrg_pkg::DstW-1:0]   o_dst_y;
    logic [sscrg_pkg::SrcW-1:0]          o_src_x;
    logic [sscrg_pkg::SrcW-1:0]          o_src_y;
    logic [sscrg_pkg::LenW-1:0]          o_run_length;
    logic [sscrg_pkg::FrameW-1:0]        o_src_frame;
    logic                                i_cfg_valid    = 1'b0;
    logic                                o_cfg_ready;
    sscrg_pkg::t_cfg_idx                 i_cfg_index    = sscrg_pkg::CFG_SPRITE_X;
    logic [sscrg_pkg::PosW-1:0]          i_cfg_data     = '0;

    // Stimulus and expectation stores
    t_span_feed                 feed_q[$];
    sscrg_pkg::t_run            runs_due[$];
    logic [sscrg_pkg::PosW-1:0] cfg_next [8];
    int           stim_left  = 0;
    int           words_made = 0;
    int           span_cap   = 8;
    int           mismatches = 0;
    int           cycle_count = 0;

    // Predictor copy of registers and walker state
    sscrg_pkg::t_cfg                 regs_now;
    logic [sscrg_pkg::RowW-1:0]      row_now     = '0;
    logic [sscrg_pkg::ColW-1:0]      col_now     = '0;
    logic [sscrg_pkg::ColW-1:0]      spans_todo  = '0;
    logic                            draw_now    = 1'b0;
    logic                            want_header = 1'b1;

    // Driver and monitor state
    int              burst_left = 0;
    int              gap_left   = 0;
    logic [15:0]     pop_pat    = '1;
    int              pat_age    = 0;
    sscrg_pkg::t_run run_seen;

    span_sprite_clip_run_generator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_span_word    (i_span_word),
        .i_frame_number (i_frame_number),
        .empty          (empty),
        .pop            (pop),
        .o_dst_x        (o_dst_x),
        .o_dst_y        (o_dst_y),
        .o_src_x        (o_src_x),
        .o_src_y        (o_src_y),
        .o_run_length   (o_run_length),
        .o_src_frame    (o_src_frame),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic note_mismatch(input string what);
        if (mismatches < 200)
            $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic cmp_field(input string name, input logic [15:0] got, input logic [15:0] want);
        if (got !== want)
            note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // Row done: advance row (wrapping at sprite height or past row 1023)
    function automatic void end_row();
        int unsigned rows;
        int unsigned nxt;
        rows = (regs_now.sprite_height == 0) ? 1 : 32'(regs_now.sprite_height);
        nxt  = 32'(row_now) + 1;
        if (nxt >= rows || nxt > 32'(sscrg_pkg::RowLast))
            nxt = 0;
        row_now     = nxt[sscrg_pkg::RowW-1:0];
        col_now     = '0;
        spans_todo  = '0;
        want_header = 1'b1;
    endfunction

    // Walk one accepted span word and queue the run it yields, if any
    function automatic void walk_span_word(input logic [sscrg_pkg::WordW-1:0] word,
                                           input logic [sscrg_pkg::FrameW-1:0] frame);
        int cnt, sx, y, w, c0, c1, lo, hi, cl, cr, ct, cb, sxo, len;
        int unsigned col_sum;
        sscrg_pkg::t_run run;
        if (want_header) begin
            cnt      = int'(word >> 1);
            draw_now = word[0];
            col_now  = '0;
            if (cnt == 0) begin
                end_row();
            end else begin
                spans_todo  = (cnt > int'(sscrg_pkg::ColMax)) ? sscrg_pkg::ColMax
                                                              : cnt[sscrg_pkg::ColW-1:0];
                want_header = 1'b0;
            end
            return;
        end
        // drawn span: clamp to sprite width, then to the clip window
        if (draw_now && word != 0) begin
            sx = int'($signed(regs_now.sprite_x));
            y  = int'($signed(regs_now.sprite_y));
            y  = y + int'(row_now);
            w  = (int'(regs_now.sprite_width) < MaxW) ? int'(regs_now.sprite_width) : MaxW;
            c0 = int'(col_now);
            c1 = c0 + int'(word);
            if (c1 > w)
                c1 = w;
            lo = sx + c0;
            hi = sx + c1;
            cl = int'(regs_now.clip_left);
            cr = int'(regs_now.clip_right);
            ct = int'(regs_now.clip_top);
            cb = int'(regs_now.clip_bottom);
            if (lo < cl)
                lo = cl;
            if (hi > cr)
                hi = cr;
            if (y >= ct && y < cb && hi > lo) begin
                sxo            = lo - sx;
                len            = hi - lo;
                run.dst_x      = lo[sscrg_pkg::DstW-1:0];
                run.dst_y      = y[sscrg_pkg::DstW-1:0];
                run.src_x      = sxo[sscrg_pkg::SrcW-1:0];
                run.src_y      = row_now;
                run.run_length = len[sscrg_pkg::LenW-1:0];
                run.src_frame  = frame;
                runs_due.push_back(run);
            end
        end
        col_sum = 32'(col_now) + 32'(word);
        if (col_sum > 32'(sscrg_pkg::ColMax))
            col_sum = 32'(sscrg_pkg::ColMax);
        col_now  = col_sum[sscrg_pkg::ColW-1:0];
        draw_now = !draw_now;
        if (spans_todo != 0)
            spans_todo--;
        if (spans_todo == 0)
            end_row();
    endfunction

    function automatic void cfg_store(input sscrg_pkg::t_cfg_idx idx,
                                      input logic [sscrg_pkg::PosW-1:0] data);
        case (idx)
            sscrg_pkg::CFG_SPRITE_X:      regs_now.sprite_x      = data;
            sscrg_pkg::CFG_SPRITE_Y:      regs_now.sprite_y      = data;
            sscrg_pkg::CFG_SPRITE_WIDTH:  regs_now.sprite_width  = data[sscrg_pkg::DimW-1:0];
            sscrg_pkg::CFG_SPRITE_HEIGHT: regs_now.sprite_height = data[sscrg_pkg::DimW-1:0];
            sscrg_pkg::CFG_CLIP_LEFT:     regs_now.clip_left     = data;
            sscrg_pkg::CFG_CLIP_TOP:      regs_now.clip_top      = data;
            sscrg_pkg::CFG_CLIP_RIGHT:    regs_now.clip_right    = data;
            sscrg_pkg::CFG_CLIP_BOTTOM:   regs_now.clip_bottom   = data;
            default: ;
        endcase
    endfunction

    // Stimulus helpers; stim_left tracks row framing on the generator side
    function automatic logic [sscrg_pkg::WordW-1:0] hdr(input int count, input bit drawn);
        return {count[14:0], drawn};
    endfunction

    function automatic void add_word(input logic [sscrg_pkg::WordW-1:0] word);
        t_span_feed f;
        f.word  = word;
        f.frame = 8'($urandom_range(0, 255));
        feed_q.push_back(f);
        words_made++;
        if (stim_left == 0) begin
            stim_left = int'(word >> 1);
            if (stim_left > int'(sscrg_pkg::ColMax))
                stim_left = int'(sscrg_pkg::ColMax);
        end else begin
            stim_left--;
        end
    endfunction

    function automatic logic [sscrg_pkg::WordW-1:0] span_len();
        int pick;
        pick = $urandom_range(0, 15);
        case (pick)
            0:       return '0;
            1:       return 16'($urandom_range(0, 65535));
            2:       return '1;
            default: return 16'($urandom_range(1, span_cap));
        endcase
    endfunction

    function automatic void close_row();
        while (stim_left > 0)
            add_word(span_len());
    endfunction

    function automatic void gen_row(input int max_spans);
        int n;
        close_row();
        n = $urandom_range(1, max_spans);
        add_word(hdr(n, 1'($urandom_range(0, 1))));
        repeat (n) add_word(span_len());
    endfunction

    // Truncated row: the following header gets eaten as a span length
    function automatic void broken_row();
        int n;
        close_row();
        n = $urandom_range(2, 6);
        add_word(hdr(n, 1'($urandom_range(0, 1))));
        repeat ($urandom_range(0, n - 1)) add_word(span_len());
        add_word(hdr($urandom_range(0, 8), 1'($urandom_range(0, 1))));
    endfunction

    function automatic void set_cfg(input int x, input int y, input int w, input int h,
                                    input int l, input int t, input int r, input int b);
        cfg_next[sscrg_pkg::CFG_SPRITE_X]      = x[sscrg_pkg::PosW-1:0];
        cfg_next[sscrg_pkg::CFG_SPRITE_Y]      = y[sscrg_pkg::PosW-1:0];
        cfg_next[sscrg_pkg::CFG_SPRITE_WIDTH]  = w[sscrg_pkg::PosW-1:0];
        cfg_next[sscrg_pkg::CFG_SPRITE_HEIGHT] = h[sscrg_pkg::PosW-1:0];
        cfg_next[sscrg_pkg::CFG_CLIP_LEFT]     = l[sscrg_pkg::PosW-1:0];
        cfg_next[sscrg_pkg::CFG_CLIP_TOP]      = t[sscrg_pkg::PosW-1:0];
        cfg_next[sscrg_pkg::CFG_CLIP_RIGHT]    = r[sscrg_pkg::PosW-1:0];
        cfg_next[sscrg_pkg::CFG_CLIP_BOTTOM]   = b[sscrg_pkg::PosW-1:0];
        span_cap = (w % 2048) / 3 + 4;
    endfunction

    function automatic void rand_config(input int flavor);
        int x, y, w, h, l, t, r, b;
        case (flavor)
            0: begin // typical visible sprite, random window
                x = $urandom_range(0, 1000) - 100;  y = $urandom_range(0, 600) - 40;
                w = $urandom_range(1, 300);         h = $urandom_range(1, 16);
                l = $urandom_range(0, 400);         t = $urandom_range(0, 300);
                r = l + $urandom_range(0, 900);     b = t + $urandom_range(0, 600);
            end
            1: begin // full screen, widest sprite
                x = 0; y = 0; w = MaxW; h = $urandom_range(1, 40);
                l = 0; t = 0; r = 4096; b = 4096;
            end
            2: begin // far right/bottom, width above the maximum
                x = $urandom_range(0, 1) ? 4095 : 4095 - $urandom_range(0, 1100);
                y = 4095 - $urandom_range(0, 6);
                w = 2047; h = $urandom_range(2, 12);
                l = $urandom_range(0, 4000); t = 0; r = 4096; b = 4096;
            end
            3: begin // far left/top
                x = $urandom_range(0, 1) ? -4096 : -$urandom_range(0, 1030);
                y = -$urandom_range(0, 8);
                w = $urandom_range(500, 1024); h = $urandom_range(1, 20);
                l = 0; t = 0; r = $urandom_range(0, 4096); b = 4096;
            end
            4: begin // empty or inverted columns, width may be zero
                x = $urandom_range(0, 300); y = $urandom_range(0, 100);
                w = $urandom_range(0, 64);  h = $urandom_range(1, 8);
                l = $urandom_range(0, 200); r = $urandom_range(0, l);
                t = $urandom_range(0, 50);  b = $urandom_range(0, 4096);
            end
            5: begin // height masks to zero, raw width data
                x = $urandom_range(0, 200); y = 0;
                w = $urandom_range(0, 8191); h = $urandom_range(0, 3) << 11;
                l = 0; t = 0; r = 4096; b = $urandom_range(0, 4096);
            end
            6: begin // one or two pixel wide window, up to three rows tall
                x = $urandom_range(0, 100); y = $urandom_range(0, 20);
                w = $urandom_range(1, 200); h = $urandom_range(1, 10);
                l = $urandom_range(0, 250); r = l + $urandom_range(1, 2);
                t = $urandom_range(0, 20);  b = t + $urandom_range(1, 3);
            end
            default: begin // anything the registers hold
                x = $urandom_range(0, 8191); y = $urandom_range(0, 8191);
                w = $urandom_range(0, 2047); h = $urandom_range(0, 2047);
                l = $urandom_range(0, 4096); t = $urandom_range(0, 4096);
                r = $urandom_range(0, 4096); b = $urandom_range(0, 4096);
            end
        endcase
        if (r > 4096)
            r = 4096;
        if (b > 4096)
            b = 4096;
        set_cfg(x, y, w, h, l, t, r, b);
    endfunction

    // Back-to-back register writes; valid stays high across the burst
    task automatic write_config();
        @(posedge i_clk);
        for (int i = 0; i < 8; i++) begin
            i_cfg_index <= sscrg_pkg::t_cfg_idx'(i);
            i_cfg_data  <= cfg_next[i];
            i_cfg_valid <= 1'b1;
            do @(posedge i_clk); while (!o_cfg_ready);
            cfg_store(sscrg_pkg::t_cfg_idx'(i), cfg_next[i]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // All items taken, all runs seen, then let the pipeline empty
    task automatic wait_idle();
        while (feed_q.size() != 0 || runs_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Driver: bursts with random gaps, holds the item while full
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push       <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (push && !full) begin
                walk_span_word(i_span_word, i_frame_number);
                void'(feed_q.pop_front());
            end
            if (push && full) begin
                // transaction pending, keep it on the bus
            end else if (gap_left > 0) begin
                gap_left--;
                push <= 1'b0;
            end else if (feed_q.size() > 0) begin
                push           <= 1'b1;
                i_span_word    <= feed_q[0].word;
                i_frame_number <= feed_q[0].frame;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 32);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end else begin
                    burst_left--;
                end
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Monitor: check each popped run, pop on a rotating stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (runs_due.size() == 0) begin
                    note_mismatch("run popped with none expected");
                end else begin
                    run_seen = runs_due.pop_front();
                    cmp_field("dst_x", 16'($unsigned(o_dst_x)), 16'(run_seen.dst_x));
                    cmp_field("dst_y", 16'($unsigned(o_dst_y)), 16'(run_seen.dst_y));
                    cmp_field("src_x", 16'(o_src_x), 16'(run_seen.src_x));
                    cmp_field("src_y", 16'(o_src_y), 16'(run_seen.src_y));
                    cmp_field("run_length", 16'(o_run_length), 16'(run_seen.run_length));
                    cmp_field("src_frame", 16'(o_src_frame), 16'(run_seen.src_frame));
                end
            end
            if (pat_age == 0) begin
                case ($urandom_range(0, 3))
                    0:       pop_pat = '1;
                    1:       pop_pat = 16'($urandom);
                    2:       pop_pat = 16'($urandom & $urandom & $urandom);
                    default: pop_pat = 16'(~($urandom & $urandom));
                endcase
                pop_pat[0] = 1'b1;
                pat_age    = $urandom_range(16, 96);
            end else begin
                pat_age--;
            end
            pop     <= pop_pat[0];
            pop_pat = {pop_pat[0], pop_pat[15:1]};
        end
    end

    // Sequence: reset, directed cases, random phases, tall sprite, saturating header
    initial begin
        int p;
        int start;
        regs_now.sprite_x      = '0;
        regs_now.sprite_y      = '0;
        regs_now.sprite_width  = 11'd1;
        regs_now.sprite_height = 11'd1;
        regs_now.clip_left     = '0;
        regs_now.clip_top      = '0;
        regs_now.clip_right    = 13'd4096;
        regs_now.clip_bottom   = 13'd4096;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: huge span clamps to width, empty rows, zero-length span
        add_word(hdr(1, 1)); add_word(16'hFFFF);
        add_word(hdr(0, 0)); add_word(hdr(0, 1));
        add_word(hdr(2, 1)); add_word(16'd0); add_word(16'd1);
        wait_idle();

        // left clip, height zero, column saturation, span past sprite width
        set_cfg(-3, 2, 20, 0, 0, 0, 10, 4096);
        write_config();
        add_word(hdr(4, 1)); add_word(16'd5); add_word(16'hFFFF);
        add_word(16'd3); add_word(16'd1);
        add_word(hdr(3, 1)); add_word(16'hFFFF); add_word(16'd4); add_word(16'd30);
        wait_idle();

        // right screen edge; first row above the clip window
        set_cfg(4095, -1, 2047, 2, 0, 0, 4096, 4096);
        write_config();
        add_word(hdr(1, 1)); add_word(16'd8);
        add_word(hdr(1, 1)); add_word(16'd8);
        wait_idle();

        // inverted clip columns
        set_cfg(0, 4095, 1024, 1, 100, 0, 50, 4096);
        write_config();
        add_word(hdr(1, 1)); add_word(16'd200);
        wait_idle();

        // random phases, mostly well-formed rows
        for (p = 0; p < 8; p++) begin
            rand_config(p);
            write_config();
            start = words_made;
            while (words_made - start < PHASE_WORDS) begin
                case ($urandom_range(0, 9))
                    0: broken_row();
                    1: begin
                        if (stim_left == 0)
                            add_word(16'($urandom_range(0, 63)));
                        else
                            add_word(16'($urandom_range(0, 65535)));
                    end
                    2: begin
                        close_row();
                        add_word(hdr(0, 1'($urandom_range(0, 1))));
                    end
                    default: gen_row(($urandom_range(0, 7) == 0) ? 24 : 6);
                endcase
            end
            wait_idle();
        end

        // tall sprite: row index wraps after row 1023
        set_cfg($urandom_range(0, 50), 0, 8, 1100, 0, 0, 4096, 4096);
        write_config();
        repeat (TALL_ROWS) begin
            if ($urandom_range(0, 31) == 0) begin
                gen_row(3);
            end else begin
                close_row();
                add_word(hdr(0, 1'($urandom_range(0, 1))));
            end
        end
        wait_idle();

        // span count above the counter range saturates
        set_cfg($urandom_range(0, 100), $urandom_range(0, 50), 1024, 4, 0, 0, 4096, 4096);
        write_config();
        close_row();
        add_word(hdr(2048 + $urandom_range(0, 30719), 1));
        repeat (12) add_word(16'($urandom_range(1, 60)));
        wait_idle();

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
